### src/base64_stream_decoder_assert.svh
// Assertion macros for the base64 stream decoder.
// Used by base64_stream_decoder.sv; expects clk and arst_n in scope.
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define B64SD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define B64SD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/b64sd_pkg.sv
// Package for the base64 stream decoder: status codes, character codes
// and the symbol lookup. No dependencies.
`default_nettype none

package b64sd_pkg;

	typedef enum logic [1:0] {
		ST_CONSUMED = 2'd0,
		ST_PAD      = 2'd1,
		ST_IGNORED  = 2'd2,
		ST_INVALID  = 2'd3
	} status_t;

	typedef struct packed {
		logic       valid;
		logic [5:0] value;
	} sym_t;

	localparam logic [7:0] CH_PAD   = 8'h3D;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SLASH   = 8'h2F;

	localparam logic [7:0] OFS_LOWER = 8'd26;
	localparam logic [7:0] OFS_DIGIT = 8'd52;
	localparam logic [5:0] VAL_PLUS  = 6'd62;
	localparam logic [5:0] VAL_SLASH = 6'd63;

	function automatic sym_t symbol_lookup(input logic [7:0] c);
		sym_t       s;
		logic [7:0] d;
		s = '0;
		d = '0;
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			d = c - CH_UPPER_A;
			s.valid = 1'b1;
			s.value = d[5:0];
		end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			d = c - CH_LOWER_A + OFS_LOWER;
			s.valid = 1'b1;
			s.value = d[5:0];
		end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
			d = c - CH_DIGIT_0 + OFS_DIGIT;
			s.valid = 1'b1;
			s.value = d[5:0];
		end else if (c == CH_PLUS) begin
			s.valid = 1'b1;
			s.value = VAL_PLUS;
		end else if (c == CH_SLASH) begin
			s.valid = 1'b1;
			s.value = VAL_SLASH;
		end
		return s;
	endfunction

endpackage

`default_nettype wire

### src/base64_stream_decoder.sv
// A character passes the input register, then the result register driving m_axis.
// Throughput: one character per cycle; the input and result registers form a
// two-stage pipeline that advances whenever the result stage is empty or taken.
// Reset: arst_n clears both valid flags and the decoder state (bit buffer,
// pending count, padding and reject flags) at once; the block is ready right after.
// Depends on b64sd_pkg and base64_stream_decoder_assert.svh.
`default_nettype none
`include "base64_stream_decoder_assert.svh"

module base64_stream_decoder
	import b64sd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,  // [7:0] char_code
	input  wire logic       s_axis_tlast,  // last_char
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,  // [7:0] data_byte
	output logic [2:0]      m_axis_tuser,  // [0] has_byte, [2:1] status
	output logic            m_axis_tlast   // text_done
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	logic       valid_s2;
	logic [7:0] byte_s2;
	logic       has_s2;
	status_t    status_s2;
	logic       last_s2;

	logic [11:0] buf_q;
	logic [2:0]  pend_q;
	logic        pad_q;
	logic        rej_q;

	logic        s2_free;
	logic        advance;
	sym_t        sym;
	logic [11:0] buf_shift;
	logic [3:0]  pend_sum;
	logic [3:0]  pend_rem;
	logic [11:0] byte_shift;

	logic [11:0] buf_d;
	logic [2:0]  pend_d;
	logic        pad_d;
	logic        rej_d;
	logic [7:0]  byte_d;
	logic        has_d;
	status_t     status_d;

	assign s2_free       = !valid_s2 || m_axis_tready;
	assign advance       = valid_s1 && s2_free;
	assign s_axis_tready = !valid_s1 || s2_free;

	assign sym        = symbol_lookup(char_s1);
	assign buf_shift  = {buf_q[5:0], sym.value};
	assign pend_sum   = {1'b0, pend_q} + 4'd6;
	assign pend_rem   = pend_sum - 4'd8;
	assign byte_shift = buf_shift >> pend_rem;

	always_comb begin
		buf_d    = buf_q;
		pend_d   = pend_q;
		pad_d    = pad_q;
		rej_d    = rej_q;
		byte_d   = '0;
		has_d    = 1'b0;
		status_d = ST_CONSUMED;
		priority if (pad_q || rej_q) begin
			status_d = ST_IGNORED;
		end else if (char_s1 == CH_PAD) begin
			pad_d    = 1'b1;
			status_d = ST_PAD;
		end else if (char_s1 == CH_CR || char_s1 == CH_LF ||
				char_s1 == CH_SPACE || char_s1 == CH_TAB) begin
			status_d = ST_CONSUMED;
		end else if (!sym.valid) begin
			rej_d    = 1'b1;
			status_d = ST_INVALID;
		end else begin
			buf_d = buf_shift;
			if (pend_sum[3]) begin
				pend_d = pend_rem[2:0];
				byte_d = byte_shift[7:0];
				has_d  = 1'b1;
			end else begin
				pend_d = pend_sum[2:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q  <= '0;
			pend_q <= '0;
			pad_q  <= 1'b0;
			rej_q  <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				buf_q  <= '0;
				pend_q <= '0;
				pad_q  <= 1'b0;
				rej_q  <= 1'b0;
			end else begin
				buf_q  <= buf_d;
				pend_q <= pend_d;
				pad_q  <= pad_d;
				rej_q  <= rej_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_s2   <= byte_d;
			has_s2    <= has_d;
			status_s2 <= status_d;
			last_s2   <= last_s1;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = byte_s2;
	assign m_axis_tuser  = {status_s2, has_s2};
	assign m_axis_tlast  = last_s2;

	`B64SD_ASSERT_IMP(a_byte_only_on_consume, valid_s2 && has_s2,
		status_s2 == ST_CONSUMED, "byte emitted with a non-consume status")
	`B64SD_ASSERT_IMP(a_byte_zero_when_none, valid_s2 && !has_s2,
		byte_s2 == 8'd0, "data byte not zero without a byte")
	`B64SD_ASSERT_IMP(a_pending_even, 1'b1, !pend_q[0], "pending bit count is odd")
	`B64SD_ASSERT_NXT(a_clear_after_last, advance && last_s1,
		pend_q == 3'd0 && !pad_q && !rej_q, "state not cleared after last character")

endmodule

`default_nettype wire

### verif/tb_base64_stream_decoder.sv
// Self-checking testbench for base64_stream_decoder: directed rows, then random texts
// with random stalls on both stream sides, checked against a behavioral decoder or a row's known result.
// Depends on b64sd_pkg and the base64_stream_decoder RTL.
module tb_base64_stream_decoder
	import b64sd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS   = 1650;
	localparam int STALL_LIMIT    = 2000;
	localparam int SQUEEZE_CYCLES = 400;
	localparam int DRAIN_CYCLES   = 8;

	typedef struct packed {
		logic [7:0] data_v;
		logic       has;
		status_t    st;
		logic       done;
	} decode_t;

	typedef struct packed {
		logic [7:0] c;
		logic       lst;
		logic       known;
		logic [7:0] data_v;
		logic       has;
		status_t    st;
	} stim_row_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic       s_axis_tlast = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic [2:0] m_axis_tuser;
	logic       m_axis_tlast;

	logic [11:0] bits_acc = '0;
	logic [2:0]  bits_pending = '0;
	logic        pad_hit = 1'b0;
	logic        text_bad = 1'b0;

	decode_t expected_q[$];
	int      mismatches = 0;
	int      idle_cycles = 0;
	int      sent_items = 0;
	logic    hold_req = 1'b0;
	logic    holding = 1'b0;
	logic    steady_tx = 1'b0;

	stim_row_t directed_rows [24] = '{
		'{"T",      1'b0, 1'b1, 8'h00, 1'b0, ST_CONSUMED},
		'{"W",      1'b0, 1'b0, 8'h00, 1'b0, ST_CONSUMED},
		'{"F",      1'b0, 1'b0, 8'h00, 1'b0, ST_CONSUMED},
		'{"u",      1'b0, 1'b0, 8'h00, 1'b0, ST_CONSUMED},
		'{CH_CR,    1'b0, 1'b1, 8'h00, 1'b0, ST_CONSUMED},
		'{CH_LF,    1'b0, 1'b1, 8'h00, 1'b0, ST_CONSUMED},
		'{CH_SPACE, 1'b0, 1'b1, 8'h00, 1'b0, ST_CONSUMED},
		'{CH_TAB,   1'b0, 1'b1, 8'h00, 1'b0, ST_CONSUMED},
		'{"/",      1'b0, 1'b0, 8'h00, 1'b0, ST_CONSUMED},
		'{"/",      1'b0, 1'b0, 8'h00, 1'b0, ST_CONSUMED},
		'{"+",      1'b1, 1'b0, 8'h00, 1'b0, ST_CONSUMED},
		'{8'hFF,    1'b0, 1'b1, 8'h00, 1'b0, ST_INVALID},
		'{CH_PAD,   1'b0, 1'b1, 8'h00, 1'b0, ST_IGNORED},
		'{8'h80,    1'b1, 1'b1, 8'h00, 1'b0, ST_IGNORED},
		'{"A",      1'b0, 1'b0, 8'h00, 1'b0, ST_CONSUMED},
		'{"A",      1'b0, 1'b0, 8'h00, 1'b0, ST_CONSUMED},
		'{CH_PAD,   1'b0, 1'b1, 8'h00, 1'b0, ST_PAD},
		'{"Z",      1'b0, 1'b1, 8'h00, 1'b0, ST_IGNORED},
		'{8'h00,    1'b1, 1'b1, 8'h00, 1'b0, ST_IGNORED},
		'{"z",      1'b0, 1'b0, 8'h00, 1'b0, ST_CONSUMED},
		'{"9",      1'b1, 1'b0, 8'h00, 1'b0, ST_CONSUMED},
		'{8'h00,    1'b1, 1'b1, 8'h00, 1'b0, ST_INVALID},
		'{"a",      1'b1, 1'b0, 8'h00, 1'b0, ST_CONSUMED},
		'{"Q",      1'b0, 1'b1, 8'h00, 1'b0, ST_CONSUMED}
	};

	base64_stream_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_CR || c == CH_LF || c == CH_SPACE || c == CH_TAB;
	endfunction

	// Returns {symbol is valid, six-bit value}.
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		if (c >= "A" && c <= "Z") begin
			return {1'b1, 6'(c - "A")};
		end
		if (c >= "a" && c <= "z") begin
			return {1'b1, 6'(c - "a" + 8'd26)};
		end
		if (c >= "0" && c <= "9") begin
			return {1'b1, 6'(c - "0" + 8'd52)};
		end
		if (c == "+") begin
			return {1'b1, 6'd62};
		end
		if (c == "/") begin
			return {1'b1, 6'd63};
		end
		return 7'd0;
	endfunction

	function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
		if (v < 6'd26) begin
			return 8'("A" + v);
		end
		if (v < 6'd52) begin
			return 8'("a" + v - 8'd26);
		end
		if (v < 6'd62) begin
			return 8'("0" + v - 8'd52);
		end
		return (v == 6'd62) ? 8'("+") : 8'("/");
	endfunction

	function automatic logic [7:0] blank_char();
		unique case ($urandom_range(0, 3))
			0: begin
				return CH_CR;
			end
			1: begin
				return CH_LF;
			end
			2: begin
				return CH_SPACE;
			end
			default: begin
				return CH_TAB;
			end
		endcase
	endfunction

	function automatic logic [7:0] invalid_char();
		logic [7:0] c;
		logic [6:0] s;
		do begin
			c = 8'($urandom_range(0, 255));
			s = sextet_of(c);
		end while (s[6] || is_blank(c) || c == CH_PAD);
		return c;
	endfunction

	// Advances the decoder state by one character and returns the result it produces.
	function automatic decode_t decode_char(input logic [7:0] c, input logic lst);
		decode_t    r;
		logic [6:0] s;
		logic [3:0] cnt;
		r.data_v = 8'h00;
		r.has = 1'b0;
		r.st = ST_CONSUMED;
		r.done = lst;
		s = sextet_of(c);
		if (pad_hit || text_bad) begin
			r.st = ST_IGNORED;
		end else if (c == CH_PAD) begin
			pad_hit = 1'b1;
			r.st = ST_PAD;
		end else if (!is_blank(c)) begin
			if (!s[6]) begin
				text_bad = 1'b1;
				r.st = ST_INVALID;
			end else begin
				bits_acc = {bits_acc[5:0], s[5:0]};
				cnt = {1'b0, bits_pending} + 4'd6;
				if (cnt >= 4'd8) begin
					cnt = cnt - 4'd8;
					r.data_v = 8'(bits_acc >> cnt);
					r.has = 1'b1;
				end
				bits_pending = cnt[2:0];
			end
		end
		if (lst) begin
			bits_acc = '0;
			bits_pending = '0;
			pad_hit = 1'b0;
			text_bad = 1'b0;
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (holding || steady_tx) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 88) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Called right after a rising edge; returns right after the edge that took the character.
	task automatic send_char(input logic [7:0] c, input logic lst, input logic known,
			input decode_t typed);
		int      gap;
		decode_t pred;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		s_axis_tlast <= lst;
		do @(posedge clk); while (!s_axis_tready);
		pred = decode_char(c, lst);
		expected_q = {expected_q, (known ? typed : pred)};
		sent_items++;
	endtask

	task automatic compare_field(input string what, input int want, input int got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	initial begin : tx_side
		logic [7:0] text_q[$];
		decode_t    typed;
		int         mode;
		int         padn;
		int         ngrp;
		int         r;
		int         k;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i]) begin
			typed.data_v = directed_rows[i].data_v;
			typed.has = directed_rows[i].has;
			typed.st = directed_rows[i].st;
			typed.done = directed_rows[i].lst;
			send_char(directed_rows[i].c, directed_rows[i].lst, directed_rows[i].known, typed);
		end
		sent_items = 0;
		hold_req = 1'b1;
		while (sent_items < RANDOM_ITEMS) begin
			text_q.delete();
			mode = $urandom_range(0, 9);
			steady_tx = ($urandom_range(0, 4) == 0);
			if (mode <= 7) begin
				// Groups of four, optionally padded, sometimes with random bytes after; mode 7 plants a bad character.
				ngrp = $urandom_range(1, 6);
				for (int g = 0; g < 4 * ngrp; g++) begin
					if ($urandom_range(0, 7) == 0) begin
						text_q = {text_q, blank_char()};
					end
					text_q = {text_q, sextet_to_char(6'($urandom_range(0, 63)))};
				end
				padn = $urandom_range(0, 2);
				for (k = 1; k <= padn; k++) begin
					text_q[text_q.size() - k] = CH_PAD;
				end
				if (mode == 7) begin
					text_q[$urandom_range(0, text_q.size() - 1)] = invalid_char();
				end
				if ($urandom_range(0, 4) == 0) begin
					repeat ($urandom_range(1, 3)) text_q = {text_q, 8'($urandom_range(0, 255))};
				end
			end else begin
				repeat ($urandom_range(1, 10)) begin
					r = $urandom_range(0, 99);
					if (r < 50) begin
						text_q = {text_q, sextet_to_char(6'($urandom_range(0, 63)))};
					end else if (r < 60) begin
						text_q = {text_q, blank_char()};
					end else if (r < 65) begin
						text_q = {text_q, CH_PAD};
					end else begin
						text_q = {text_q, 8'($urandom_range(0, 255))};
					end
				end
			end
			for (k = 0; k < text_q.size(); k++) begin
				send_char(text_q[k], k == text_q.size() - 1, 1'b0, '0);
			end
		end
		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin : rx_side
		int stall;
		int run;
		int r;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				// Long hold-off so the pipeline fills and back-pressures the input.
				hold_req = 1'b0;
				holding = 1'b1;
				stall = SQUEEZE_CYCLES;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					stall = 0;
				end else if (r < 85) begin
					stall = $urandom_range(1, 3);
				end else if (r < 97) begin
					stall = $urandom_range(4, 12);
				end else begin
					stall = $urandom_range(20, 60);
				end
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			holding = 1'b0;
			m_axis_tready <= 1'b1;
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 8);
			repeat (run) @(posedge clk);
		end
	end

	always @(posedge clk) begin : check_results
		decode_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected transaction, byte %0d user %0d last %0d", $time,
						m_axis_tdata, m_axis_tuser, m_axis_tlast);
				end else begin
					want = expected_q.pop_front();
					compare_field("data_byte", want.data_v, m_axis_tdata);
					compare_field("has_byte", want.has, m_axis_tuser[0]);
					compare_field("status", int'(want.st), m_axis_tuser[2:1]);
					compare_field("text_done", want.done, m_axis_tlast);
				end
			end
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, idle_cycles);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

endmodule
